FILE: sv/plsu_pkg.sv
// Package for the positional list store: sizes, status codes, opcodes and the
// command struct that the controller broadcasts to every storage cell.
// No dependencies.
package plsu_pkg;

	localparam int DEPTH   = 64;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int OP_W    = 3;
	localparam int POS_W   = 7;
	localparam int DATA_W  = 32;
	localparam int STAT_W  = 3;
	localparam int FPOS_W  = 6;
	localparam int COUNT_W = 7;
	localparam int CMP_W   = (POS_W > CNT_W) ? POS_W : CNT_W;

	localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
	localparam logic [STAT_W-1:0] ST_RANGE    = 3'd1;
	localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
	localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd3;
	localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_INSERT_AT  = 3'd2,
		OP_POP_FRONT  = 3'd3,
		OP_POP_BACK   = 3'd4,
		OP_DELETE_AT  = 3'd5,
		OP_READ_AT    = 3'd6,
		OP_SEARCH     = 3'd7
	} opcode_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_DELETE,
		CELL_ROTATE
	} cell_op_t;

	typedef struct packed {
		cell_op_t                  kind;
		logic [CMP_W-1:0]          at;
		logic signed [DATA_W-1:0]  value;
	} cell_cmd_t;

endpackage

FILE: sv/plsu_cell.sv
// One storage cell of the positional list store chain.
// Holds one entry and takes data from either neighbor or from the broadcast
// command. Depends on plsu_pkg.
module plsu_cell import plsu_pkg::*; (
	input  logic                      clk,
	input  cell_cmd_t                 cmd,
	input  logic [IDX_W-1:0]          index,
	input  logic signed [DATA_W-1:0]  below,
	input  logic signed [DATA_W-1:0]  above,
	output logic signed [DATA_W-1:0]  data
);

	logic signed [DATA_W-1:0] data_q;
	logic signed [DATA_W-1:0] data_d;
	logic [CMP_W-1:0]         idx_x;

	assign idx_x = CMP_W'(index);

	always_comb begin
		data_d = data_q;
		case (cmd.kind)
			CELL_INSERT: begin
				if (idx_x == cmd.at) begin
					data_d = cmd.value;
				end else if (idx_x > cmd.at) begin
					data_d = below;
				end
			end
			CELL_DELETE: begin
				if (idx_x >= cmd.at) begin
					data_d = above;
				end
			end
			CELL_ROTATE: begin
				data_d = above;
			end
			default: begin
				data_d = data_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;

endmodule

FILE: sv/positional_list_store_unit.sv
// Top level of the positional list store: controller plus a chain of storage
// cells. Depends on plsu_pkg and plsu_cell.
//
// Channel   Direction  Signals                                          Handshake
// request   in         start, operation, position, value, busy          start && !busy
// result    out        strobe, status, read_value, found_position,
//                      entry_count                                      strobe, one cycle
//
// Push, pop, insert and delete complete in one cycle; the result appears on
// the cycle after acceptance and a new transaction may be accepted at once.
// Read and search rotate the whole chain once past cell 0, which takes DEPTH
// cycles, with busy high; the result follows on the next cycle.
// A read at a position at or beyond the count is answered in one cycle.
// Reset clears the count and the controller; cell contents are not reset.
// The receiver cannot stall the result.
module positional_list_store_unit import plsu_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [OP_W-1:0]            operation,
	input  logic [POS_W-1:0]           position,
	input  logic signed [DATA_W-1:0]   value,
	output logic                       strobe,
	output logic [STAT_W-1:0]          status,
	output logic signed [DATA_W-1:0]   read_value,
	output logic [FPOS_W-1:0]          found_position,
	output logic [COUNT_W-1:0]         entry_count
);

	typedef enum logic {
		S_IDLE,
		S_SCAN
	} state_t;

	state_t                    state_q;
	logic [CNT_W-1:0]          count_q;
	logic [IDX_W-1:0]          step_q;
	logic                      search_q;
	logic                      hit_q;
	logic [IDX_W-1:0]          fpos_q;
	logic [CMP_W-1:0]          pos_q;
	logic signed [DATA_W-1:0]  val_q;
	logic signed [DATA_W-1:0]  rd_q;

	logic                      strobe_q;
	logic [STAT_W-1:0]         status_q;
	logic signed [DATA_W-1:0]  read_value_q;
	logic [FPOS_W-1:0]         found_position_q;
	logic [COUNT_W-1:0]        entry_count_q;

	cell_cmd_t                 cmd;
	logic signed [DATA_W-1:0]  cell_data [DEPTH];

	logic                      accept;
	logic [CMP_W-1:0]          cnt_x;
	logic [CMP_W-1:0]          pos_x;
	logic [CMP_W-1:0]          ins_at;
	logic [CMP_W-1:0]          del_at;
	logic                      imm_done;
	logic                      scan_go;
	logic [STAT_W-1:0]         imm_status;
	logic signed [DATA_W-1:0]  imm_rd;
	logic [CNT_W-1:0]          next_count;
	logic                      step_in_range;
	logic                      cur_hit;
	logic                      cur_read;
	logic                      last_step;

	assign accept = start && !busy;
	assign cnt_x  = CMP_W'(count_q);
	assign pos_x  = CMP_W'(position);

	always_comb begin
		cmd.kind   = CELL_HOLD;
		cmd.at     = '0;
		cmd.value  = value;
		imm_done   = 1'b0;
		scan_go    = 1'b0;
		imm_status = ST_OK;
		imm_rd     = '0;
		next_count = count_q;
		ins_at     = '0;
		del_at     = '0;
		if (state_q == S_SCAN) begin
			cmd.kind = CELL_ROTATE;
		end else if (accept) begin
			case (opcode_t'(operation))
				OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT_AT: begin
					imm_done = 1'b1;
					if (opcode_t'(operation) == OP_PUSH_BACK) begin
						ins_at = cnt_x;
					end else if (opcode_t'(operation) == OP_INSERT_AT) begin
						ins_at = pos_x;
					end
					if (ins_at > cnt_x) begin
						imm_status = ST_RANGE;
					end else if (count_q >= CNT_W'(DEPTH)) begin
						imm_status = ST_FULL;
					end else begin
						cmd.kind   = CELL_INSERT;
						cmd.at     = ins_at;
						next_count = count_q + CNT_W'(1);
					end
				end
				OP_POP_FRONT, OP_POP_BACK, OP_DELETE_AT: begin
					imm_done = 1'b1;
					if (opcode_t'(operation) == OP_POP_BACK) begin
						del_at = cnt_x - CMP_W'(1);
					end else if (opcode_t'(operation) == OP_DELETE_AT) begin
						del_at = pos_x;
					end
					if (count_q == '0) begin
						imm_status = ST_EMPTY;
					end else if (del_at >= cnt_x) begin
						imm_status = ST_RANGE;
					end else begin
						cmd.kind   = CELL_DELETE;
						cmd.at     = del_at;
						next_count = count_q - CNT_W'(1);
					end
				end
				OP_READ_AT: begin
					if (pos_x < cnt_x) begin
						scan_go = 1'b1;
					end else begin
						imm_done   = 1'b1;
						imm_status = ST_RANGE;
						imm_rd     = '1;
					end
				end
				default: begin
					scan_go = 1'b1;
				end
			endcase
		end
	end

	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		plsu_cell u_cell (
			.clk   (clk),
			.cmd   (cmd),
			.index (IDX_W'(k)),
			.below ((k == 0) ? '0 : cell_data[(k == 0) ? 0 : k - 1]),
			.above (cell_data[(k + 1) % DEPTH]),
			.data  (cell_data[k])
		);
	end

	assign step_in_range = CMP_W'(step_q) < cnt_x;
	assign cur_hit       = search_q && !hit_q && step_in_range && (cell_data[0] == val_q);
	assign cur_read      = CMP_W'(step_q) == pos_q;
	assign last_step     = step_q == IDX_W'(DEPTH - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= S_IDLE;
			count_q          <= '0;
			step_q           <= '0;
			search_q         <= 1'b0;
			hit_q            <= 1'b0;
			fpos_q           <= '0;
			pos_q            <= '0;
			val_q            <= '0;
			rd_q             <= '0;
			strobe_q         <= 1'b0;
			status_q         <= ST_OK;
			read_value_q     <= '0;
			found_position_q <= '0;
			entry_count_q    <= '0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					count_q <= next_count;
					if (imm_done) begin
						strobe_q         <= 1'b1;
						status_q         <= imm_status;
						read_value_q     <= imm_rd;
						found_position_q <= '0;
						entry_count_q    <= COUNT_W'(next_count);
					end
					if (scan_go) begin
						state_q  <= S_SCAN;
						step_q   <= '0;
						search_q <= opcode_t'(operation) == OP_SEARCH;
						hit_q    <= 1'b0;
						fpos_q   <= '0;
						pos_q    <= pos_x;
						val_q    <= value;
						rd_q     <= '0;
					end
				end
				S_SCAN: begin
					step_q <= step_q + IDX_W'(1);
					if (cur_hit) begin
						hit_q  <= 1'b1;
						fpos_q <= step_q;
					end
					if (cur_read) begin
						rd_q <= cell_data[0];
					end
					if (last_step) begin
						state_q       <= S_IDLE;
						strobe_q      <= 1'b1;
						entry_count_q <= COUNT_W'(count_q);
						if (search_q) begin
							read_value_q <= '0;
							if (hit_q || cur_hit) begin
								status_q         <= ST_OK;
								found_position_q <= FPOS_W'(hit_q ? fpos_q : step_q);
							end else begin
								status_q         <= ST_NOTFOUND;
								found_position_q <= '0;
							end
						end else begin
							status_q         <= ST_OK;
							found_position_q <= '0;
							read_value_q     <= cur_read ? cell_data[0] : rd_q;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy           = state_q == S_SCAN;
	assign strobe         = strobe_q;
	assign status         = status_q;
	assign read_value     = read_value_q;
	assign found_position = found_position_q;
	assign entry_count    = entry_count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("Entry count exceeds the store depth.");

	a_scan_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && last_step) |=> (strobe && !busy))
		else $error("A scan did not end with a result.");

	a_scan_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> !strobe)
		else $error("A result appeared when a scan began.");

	a_notfound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && status == ST_NOTFOUND) |-> (found_position == '0))
		else $error("A failed search reported a nonzero position.");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |=> $stable(count_q))
		else $error("The count changed during a scan.");

endmodule
